// File: hdl/lagstep_pkg.sv
// shared types and constants for the life automaton grid step block
// no dependencies; imported by life_automaton_grid_step_top and its testbench
package lagstep_pkg;

   // default grid storage size
   localparam int MAX_COLS_DEF = 128;
   localparam int MAX_ROWS_DEF = 128;

   // fixed field widths
   localparam int CMD_W  = 2;
   localparam int COL_W  = 7;
   localparam int ROW_W  = 7;
   localparam int CSR_W  = 8;
   localparam int CIDX_W = 2;

   // command codes
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_STEP  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   // configuration register indexes
   localparam logic [CIDX_W-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CIDX_W-1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [CIDX_W-1:0] CSR_RUN_ENABLE  = 2'd2;

   localparam logic [CSR_W-1:0] GRID_SIZE_MIN   = 8'd3;
   localparam logic [CSR_W-1:0] GRID_SIZE_RESET = 8'd128;

   // b3/s23 rule
   localparam logic [3:0] BIRTH_COUNT  = 4'd3;
   localparam logic [3:0] SURVIVE_LOW  = 4'd2;
   localparam logic [3:0] SURVIVE_HIGH = 4'd3;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             cell_value;
   } req_payload_type;

   typedef struct packed {
      logic read_value;
      logic stepped;
   } rsp_payload_type;

endpackage

// File: hdl/life_automaton_grid_step_top.sv
// life automaton grid step: b3/s23 cell grid with cell write, cell read and step
// depends on lagstep_pkg
//
//  channel  | ports                       | moves
//  ---------+-----------------------------+------------------------------------
//  request  | req_valid req_stall req_data| cmd, col, row, cell_value
//  result   | rsp_valid rsp_stall rsp_data| read_value, stepped
//  config   | csr_we csr_index csr_wdata  | grid_width, grid_height, run_enable
//
// one request at a time; a write or read of a cell inside the grid passes the access
// and done states to a waiting result, every other request except an enabled step
// goes straight to the done state; an enabled step loads rows 0 and 1, then the single
// neighbor count unit handles one cell a cycle and the row state writes back each row
// after reset a clearing pass writes one grid row a cycle, all MAX_ROWS rows,
// before the first request is taken
// a stalled result holds in the output register; the next request is taken meanwhile
module life_automaton_grid_step_top #(
   parameter int MAX_COLS = lagstep_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = lagstep_pkg::MAX_ROWS_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  lagstep_pkg::req_payload_type                req_data,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output lagstep_pkg::rsp_payload_type                rsp_data,
   input  logic                                        csr_we,
   input  logic [lagstep_pkg::CIDX_W-1:0]              csr_index,
   input  logic [lagstep_pkg::CSR_W-1:0]               csr_wdata
);
   import lagstep_pkg::*;

   localparam int CI_W = $clog2(MAX_COLS);
   localparam int RI_W = $clog2(MAX_ROWS);

   typedef enum logic [7:0] {
      S_CLEAR  = 8'b0000_0001,
      S_IDLE   = 8'b0000_0010,
      S_ACCESS = 8'b0000_0100,
      S_LOAD0  = 8'b0000_1000,
      S_LOAD1  = 8'b0001_0000,
      S_CELL   = 8'b0010_0000,
      S_ROW    = 8'b0100_0000,
      S_DONE   = 8'b1000_0000
   } state_type;

   // grid storage, one row per entry
   logic [MAX_COLS-1:0] grid_mem [MAX_ROWS];
   logic [MAX_COLS-1:0] rd_data_ff;
   logic                mem_we;
   logic [RI_W-1:0]     mem_waddr;
   logic [MAX_COLS-1:0] mem_wdata;
   logic                mem_re;
   logic [RI_W-1:0]     mem_raddr;

   state_type           state_ff, state_in;
   logic [CSR_W-1:0]    grid_width_ff, grid_width_in;
   logic [CSR_W-1:0]    grid_height_ff, grid_height_in;
   logic                run_enable_ff, run_enable_in;
   req_payload_type     req_ff, req_in;
   rsp_payload_type     res_ff, res_in;
   rsp_payload_type     rsp_data_ff, rsp_data_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RI_W-1:0]     r_ff, r_in;
   logic [CI_W-1:0]     c_ff, c_in;
   logic [MAX_COLS-1:0] up_ff, up_in;
   logic [MAX_COLS-1:0] mid_ff, mid_in;
   logic [MAX_COLS-1:0] dn_ff, dn_in;
   logic [MAX_COLS-1:0] new_ff, new_in;

   logic [CI_W:0]       w;
   logic [RI_W:0]       h;
   logic                in_inside;
   logic [RI_W-1:0]     in_row_idx;
   logic [CI_W-1:0]     acc_col_idx;
   logic [RI_W-1:0]     acc_row_idx;
   logic [MAX_COLS-1:0] row_mod;
   logic [CI_W-1:0]     c_m1, c_p1;
   logic                has_left, has_right;
   logic [3:0]          n_count;
   logic                cell_next;
   logic                last_col, last_row;
   logic [RI_W+1:0]     r_p2;
   logic                r_p2_in_grid;

   // grid size in use, clamped to [3, max]
   always_comb begin
      if (grid_width_ff < GRID_SIZE_MIN) begin
         w = (CI_W+1)'(GRID_SIZE_MIN);
      end else if (32'(grid_width_ff) > MAX_COLS) begin
         w = (CI_W+1)'(MAX_COLS);
      end else begin
         w = (CI_W+1)'(grid_width_ff);
      end
      if (grid_height_ff < GRID_SIZE_MIN) begin
         h = (RI_W+1)'(GRID_SIZE_MIN);
      end else if (32'(grid_height_ff) > MAX_ROWS) begin
         h = (RI_W+1)'(MAX_ROWS);
      end else begin
         h = (RI_W+1)'(grid_height_ff);
      end
   end

   assign in_inside   = (32'(req_data.col) < 32'(w)) && (32'(req_data.row) < 32'(h));
   assign in_row_idx  = RI_W'(32'(req_data.row));
   assign acc_col_idx = CI_W'(32'(req_ff.col));
   assign acc_row_idx = RI_W'(32'(req_ff.row));

   always_comb begin
      row_mod = rd_data_ff;
      row_mod[acc_col_idx] = req_ff.cell_value;
   end

   // shared neighbor count unit, one cell per cycle
   assign c_m1      = c_ff - CI_W'(1);
   assign c_p1      = c_ff + CI_W'(1);
   assign has_left  = (c_ff != '0);
   assign has_right = ((32'(c_ff) + 1) < 32'(w));

   always_comb begin
      n_count = 4'(up_ff[c_ff]) + 4'(dn_ff[c_ff])
              + 4'(has_left  & up_ff[c_m1])  + 4'(has_left  & mid_ff[c_m1])
              + 4'(has_left  & dn_ff[c_m1])
              + 4'(has_right & up_ff[c_p1])  + 4'(has_right & mid_ff[c_p1])
              + 4'(has_right & dn_ff[c_p1]);
      if (mid_ff[c_ff]) begin
         cell_next = (n_count >= SURVIVE_LOW) && (n_count <= SURVIVE_HIGH);
      end else begin
         cell_next = (n_count == BIRTH_COUNT);
      end
   end

   assign last_col     = (32'(c_ff) + 1 == 32'(w));
   assign last_row     = (32'(r_ff) + 1 == 32'(h));
   assign r_p2         = {2'b00, r_ff} + (RI_W+2)'(2);
   assign r_p2_in_grid = (r_p2 < (RI_W+2)'(h));

   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      run_enable_in  = run_enable_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_GRID_WIDTH:  grid_width_in  = csr_wdata;
            CSR_GRID_HEIGHT: grid_height_in = csr_wdata;
            CSR_RUN_ENABLE:  run_enable_in  = csr_wdata[0];
            default:         ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      r_in         = r_ff;
      c_in         = c_ff;
      up_in        = up_ff;
      mid_in       = mid_ff;
      dn_in        = dn_ff;
      new_in       = new_ff;
      mem_we       = 1'b0;
      mem_waddr    = r_ff;
      mem_wdata    = new_ff;
      mem_re       = 1'b0;
      mem_raddr    = r_ff;

      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = '0;
            r_in      = r_ff + RI_W'(1);
            if (r_ff == RI_W'(MAX_ROWS - 1)) begin
               r_in     = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               res_in = '0;
               case (req_data.cmd)
                  CMD_WRITE, CMD_READ: begin
                     if (in_inside) begin
                        mem_re    = 1'b1;
                        mem_raddr = in_row_idx;
                        state_in  = S_ACCESS;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
                  CMD_STEP: begin
                     if (run_enable_ff) begin
                        mem_re    = 1'b1;
                        mem_raddr = '0;
                        r_in      = '0;
                        state_in  = S_LOAD0;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_ACCESS: begin
            // read-modify-write of the addressed row, or a bit pick for a read
            if (req_ff.cmd == CMD_WRITE) begin
               mem_we    = 1'b1;
               mem_waddr = acc_row_idx;
               mem_wdata = row_mod;
            end else begin
               res_in.read_value = rd_data_ff[acc_col_idx];
            end
            state_in = S_DONE;
         end
         S_LOAD0: begin
            up_in     = '0;
            mid_in    = rd_data_ff;
            new_in    = rd_data_ff;
            mem_re    = 1'b1;
            mem_raddr = RI_W'(1);
            state_in  = S_LOAD1;
         end
         S_LOAD1: begin
            dn_in    = rd_data_ff;
            c_in     = '0;
            state_in = S_CELL;
         end
         S_CELL: begin
            new_in[c_ff] = cell_next;
            c_in         = c_ff + CI_W'(1);
            if (last_col) begin
               // fetch the row that slides into the window next
               mem_re    = 1'b1;
               mem_raddr = RI_W'(r_p2);
               state_in  = S_ROW;
            end
         end
         S_ROW: begin
            // new row goes back; old rows stay in the window for the next row
            mem_we = 1'b1;
            up_in  = mid_ff;
            mid_in = dn_ff;
            new_in = dn_ff;
            dn_in  = r_p2_in_grid ? rd_data_ff : '0;
            c_in   = '0;
            if (last_row) begin
               res_in.stepped = 1'b1;
               state_in       = S_DONE;
            end else begin
               r_in     = r_ff + RI_W'(1);
               state_in = S_CELL;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= grid_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         grid_width_ff  <= GRID_SIZE_RESET;
         grid_height_ff <= GRID_SIZE_RESET;
         run_enable_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         r_ff           <= '0;
      end else begin
         state_ff       <= state_in;
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         run_enable_ff  <= run_enable_in;
         rsp_valid_ff   <= rsp_valid_in;
         r_ff           <= r_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      c_ff        <= c_in;
      up_ff       <= up_in;
      mid_ff      <= mid_in;
      dn_ff       <= dn_in;
      new_ff      <= new_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   state_onehot_a: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");

   rsp_from_done_a: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result raised outside the done state");

   cell_in_grid_a: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CELL |-> (32'(c_ff) < 32'(w)) && (32'(r_ff) < 32'(h)))
      else $error("step visits a cell outside the grid in use");

   stepped_needs_enable_a: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROW && last_row) |-> run_enable_ff)
      else $error("generation advanced while stepping disabled");
`endif

endmodule

// File: dv/life_automaton_grid_step_top_tb.sv
// testbench for life_automaton_grid_step_top: cell writes, reads and b3/s23 steps
// checked against a bit-level grid predictor; depends on lagstep_pkg and the top level
`timescale 1ns / 100ps

module life_automaton_grid_step_top_tb;
   import lagstep_pkg::*;

   localparam logic [CMD_W-1:0]  CMD_UNUSED  = 2'd3;
   localparam logic [CIDX_W-1:0] CSR_UNUSED  = 2'd3;
   localparam int                QUIET_LIMIT = 60000;
   localparam int                RANDOM_ITEMS = 80;

   class life_grid_scoreboard;
      bit [MAX_COLS_DEF-1:0] cur_rows [MAX_ROWS_DEF];
      bit [CSR_W-1:0]        width_reg;
      bit [CSR_W-1:0]        height_reg;
      bit                    enable_reg;
      rsp_payload_type       expected_q[$];
      int                    errors;

      function new();
         foreach (cur_rows[r]) cur_rows[r] = '0;
         width_reg  = GRID_SIZE_RESET;
         height_reg = GRID_SIZE_RESET;
         enable_reg = 1'b0;
         errors     = 0;
      endfunction

      function int clamp_size(bit [CSR_W-1:0] v, int maxv);
         if (v < GRID_SIZE_MIN) return int'(GRID_SIZE_MIN);
         if (v > maxv) return maxv;
         return int'(v);
      endfunction

      function int used_cols();
         return clamp_size(width_reg, MAX_COLS_DEF);
      endfunction

      function int used_rows();
         return clamp_size(height_reg, MAX_ROWS_DEF);
      endfunction

      function void apply_csr(logic [CIDX_W-1:0] idx, logic [CSR_W-1:0] v);
         case (idx)
            CSR_GRID_WIDTH:  width_reg  = v;
            CSR_GRID_HEIGHT: height_reg = v;
            CSR_RUN_ENABLE:  enable_reg = v[0];
            default: ;
         endcase
      endfunction

      // neighbors outside the grid in use count as dead
      function int live_at(int c, int r, int w, int h);
         if (c < 0 || r < 0 || c >= w || r >= h) return 0;
         return int'(cur_rows[r][c]);
      endfunction

      function void advance_generation();
         bit [MAX_COLS_DEF-1:0] next_rows [MAX_ROWS_DEF];
         int w, h, n;
         w = used_cols();
         h = used_rows();
         next_rows = cur_rows;
         for (int r = 0; r < h; r++) begin
            for (int c = 0; c < w; c++) begin
               n = 0;
               for (int dy = -1; dy <= 1; dy++)
                  for (int dx = -1; dx <= 1; dx++)
                     if (dx != 0 || dy != 0) n += live_at(c + dx, r + dy, w, h);
               if (cur_rows[r][c])
                  next_rows[r][c] = (n >= SURVIVE_LOW && n <= SURVIVE_HIGH);
               else
                  next_rows[r][c] = (n == BIRTH_COUNT);
            end
         end
         cur_rows = next_rows;
      endfunction

      function void note_request(req_payload_type p);
         rsp_payload_type e;
         bit in_grid;
         e = '0;
         in_grid = (p.col < used_cols()) && (p.row < used_rows());
         case (p.cmd)
            CMD_WRITE: if (in_grid) cur_rows[p.row][p.col] = p.cell_value;
            CMD_STEP: begin
               if (enable_reg) begin
                  advance_generation();
                  e.stepped = 1'b1;
               end
            end
            CMD_READ: if (in_grid) e.read_value = cur_rows[p.row][p.col];
            default: ;
         endcase
         expected_q.push_back(e);
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type e;
         if (expected_q.size() == 0) begin
            $error("result with no request outstanding: %b", got);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (got.read_value !== e.read_value) begin
            $error("read_value: expected %b, actual %b", e.read_value, got.read_value);
            errors++;
         end
         if (got.stepped !== e.stepped) begin
            $error("stepped: expected %b, actual %b", e.stepped, got.stepped);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_payload_type     req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_payload_type     rsp_data;
   logic                csr_we = 1'b0;
   logic [CIDX_W-1:0]   csr_index = '0;
   logic [CSR_W-1:0]    csr_wdata = '0;

   life_grid_scoreboard sb = new();
   bit                  calm = 1'b0;
   int                  stall_run = 0;
   int                  quiet_cycles = 0;

   life_automaton_grid_step_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // handshakes are seen here only, so requests and results keep their order
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) sb.note_request(req_data);
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   // result side back-pressure in bursts
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
         stall_run <= 0;
      end else if (stall_run > 0) begin
         stall_run <= stall_run - 1;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
         stall_run <= $urandom_range(0, 40);
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         stall_run <= $urandom_range(0, 15);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("life_automaton_grid_step_top: mismatch");
            $finish;
         end
      end
   end

   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [COL_W-1:0] col,
                               input logic [ROW_W-1:0] row, input logic value);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{cmd: cmd, col: col, row: row, cell_value: value};
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   // let the clock advance first so the request accepted at the last edge is already noted
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // block must be idle; the trailing write hits an index the block ignores
   task automatic configure(input logic [CSR_W-1:0] w, input logic [CSR_W-1:0] h,
                            input logic en);
      csr_we    <= 1'b1;
      csr_index <= CSR_GRID_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      sb.apply_csr(CSR_GRID_WIDTH, w);
      csr_index <= CSR_GRID_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      sb.apply_csr(CSR_GRID_HEIGHT, h);
      csr_index <= CSR_RUN_ENABLE;
      csr_wdata <= (CSR_W'($urandom) & 8'hfe) | CSR_W'(en);
      @(posedge clock);
      sb.apply_csr(CSR_RUN_ENABLE, CSR_W'(en));
      csr_index <= CSR_UNUSED;
      csr_wdata <= CSR_W'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_request();
      int w, h, pick;
      logic [COL_W-1:0] c;
      logic [ROW_W-1:0] r;
      w = sb.used_cols();
      h = sb.used_rows();
      pick = $urandom_range(0, 99);
      c = COL_W'($urandom_range(0, w - 1));
      r = ROW_W'($urandom_range(0, h - 1));
      if (pick < 40)
         send_request(CMD_WRITE, c, r, $urandom_range(0, 4) != 0);
      else if (pick < 75)
         send_request(CMD_READ, c, r, 1'($urandom));
      else if (pick < 88)
         send_request(CMD_STEP, COL_W'($urandom), ROW_W'($urandom), 1'($urandom));
      else if (pick < 92)
         send_request(CMD_UNUSED, COL_W'($urandom), ROW_W'($urandom), 1'($urandom));
      else
         send_request($urandom_range(0, 1) ? CMD_WRITE : CMD_READ,
                      COL_W'($urandom), ROW_W'($urandom), 1'($urandom));
   endtask

   function automatic logic [CSR_W-1:0] pick_size();
      int p;
      p = $urandom_range(0, 19);
      if (p < 15) return CSR_W'($urandom_range(3, 16));
      if (p < 17) return CSR_W'($urandom_range(0, 2));
      return CSR_W'($urandom_range(17, 255));
   endfunction

   initial begin
      logic [CSR_W-1:0] w, h;
      int sent;
      sent = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset state: full grid, all dead, stepping off
      send_request(CMD_READ, 7'd0, 7'd0, 1'b1);
      send_request(CMD_READ, 7'd127, 7'd127, 1'b0);
      send_request(CMD_WRITE, 7'd127, 7'd127, 1'b1);
      send_request(CMD_READ, 7'd127, 7'd127, 1'b0);
      send_request(CMD_STEP, 7'd127, 7'd127, 1'b1);
      send_request(CMD_UNUSED, 7'd127, 7'd127, 1'b1);
      send_request(CMD_WRITE, 7'd0, 7'd0, 1'b1);
      send_request(CMD_WRITE, 7'd1, 7'd0, 1'b1);
      send_request(CMD_WRITE, 7'd2, 7'd0, 1'b1);
      wait_drained();

      // one full-size generation; blinker on the top edge, lone cell in the corner
      configure(8'd128, 8'd128, 1'b1);
      send_request(CMD_STEP, 7'd0, 7'd0, 1'b0);
      send_request(CMD_READ, 7'd1, 7'd1, 1'b0);
      send_request(CMD_READ, 7'd127, 7'd127, 1'b0);
      wait_drained();

      // smallest grid; writes outside it are dropped
      configure(8'd3, 8'd3, 1'b1);
      send_request(CMD_WRITE, 7'd3, 7'd0, 1'b1);
      send_request(CMD_READ, 7'd3, 7'd0, 1'b0);
      send_request(CMD_STEP, 7'd0, 7'd0, 1'b0);
      send_request(CMD_READ, 7'd1, 7'd0, 1'b0);
      wait_drained();

      // sizes out of range get clamped
      configure(8'd0, 8'd255, 1'b1);
      send_request(CMD_STEP, 7'd0, 7'd0, 1'b0);
      send_request(CMD_READ, 7'd0, 7'd127, 1'b0);
      wait_drained();
      configure(8'd255, 8'd2, 1'b0);
      send_request(CMD_STEP, 7'd0, 7'd0, 1'b0);
      send_request(CMD_READ, 7'd127, 7'd2, 1'b0);

      while (sent < RANDOM_ITEMS) begin
         wait_drained();
         w = pick_size();
         h = pick_size();
         // never keep a grid both wide and tall, so steps stay short
         if (w > 16 && h > 16) h = CSR_W'($urandom_range(3, 8));
         configure(w, h, $urandom_range(0, 6) != 0);
         if (sent >= RANDOM_ITEMS - 15) calm = 1'b1;
         repeat ($urandom_range(8, 20)) begin
            if (!calm && $urandom_range(0, 19) == 0) wait_drained();
            random_request();
            sent++;
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("life_automaton_grid_step_top: match");
      else
         $display("life_automaton_grid_step_top: mismatch");
      $finish;
   end

endmodule

// File: life_automaton_grid_step_top.f
hdl/lagstep_pkg.sv
hdl/life_automaton_grid_step_top.sv
dv/life_automaton_grid_step_top_tb.sv
